@@ sv/lkdl_pkg.sv @@
`default_nettype none

package lkdl_pkg;

	// Digit storage depth.
	localparam int MAX_DIGITS = 4;

	// Command bytes of the display chip.
	localparam logic [7:0] CMD_CONTROL = 8'h48;
	localparam logic [7:0] CMD_KEYREAD = 8'h49;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_DIGIT_COUNT     = 2'd0;
	localparam logic [1:0] REG_BASE_ADDR       = 2'd1;
	localparam logic [1:0] REG_DISPLAY_CONTROL = 2'd2;

	// Configuration reset values.
	localparam logic [2:0] DIGIT_COUNT_RST     = 3'd4;
	localparam logic [7:0] BASE_ADDR_RST       = 8'd110;
	localparam logic [7:0] DISPLAY_CONTROL_RST = 8'd1;

	typedef struct packed {
		logic [2:0] digit_count;
		logic [7:0] base_addr;
		logic [7:0] display_control;
	} lkdl_cfg_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] digit_index;
		logic [7:0] digit_value;
		logic       sda_in;
	} lkdl_in_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic [7:0] key_data;
		logic       link_alive;
	} lkdl_out_t;

endpackage

`default_nettype wire

@@ sv/lkdl_core.sv @@
`default_nettype none

module lkdl_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_en,
	input  wire lkdl_pkg::lkdl_in_t  item,
	input  wire lkdl_pkg::lkdl_cfg_t cfg,
	output lkdl_pkg::lkdl_out_t      res_nxt
);
	import lkdl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CFG_ALIVE,
		ST_DIGIT,
		ST_CFG_DEAD
	} step_t;

	localparam logic [5:0] PH_STOP = 6'd39;

	step_t      step_q, step_n;
	logic [5:0] phase_q, phase_n;
	logic [7:0] shift_q, shift_n;
	logic [2:0] cursor_q, cursor_n;
	logic [7:0] addr_q, addr_n;
	logic [7:0] sent_ctl_q, sent_ctl_n;
	logic [7:0] key_q, key_n;
	logic       alive_q, alive_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic [7:0] pending_q [MAX_DIGITS];
	logic [7:0] pending_n [MAX_DIGITS];
	logic [7:0] sent_q [MAX_DIGITS];
	logic [7:0] sent_n [MAX_DIGITS];

	logic [3:0] eff_cnt;
	logic       changed;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic [7:0] cursor_digit;
	logic [5:0] ph_q;
	logic       ph_second;
	logic [5:0] ph_q2;
	logic [3:0] ph_bit;
	logic       ph_half;
	logic [7:0] shifted;
	logic [3:0] cursor_inc;

	assign eff_cnt = ({1'b0, cfg.digit_count} > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS)
		: {1'b0, cfg.digit_count};

	always_comb begin
		changed = 1'b0;
		cursor_digit = 8'h00;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (4'(i) < eff_cnt && sent_q[i] != pending_q[i])
				changed = 1'b1;
			if (4'(cursor_q) == 4'(i))
				cursor_digit = sent_q[i];
		end
	end

	always_comb begin
		unique case (step_q)
			ST_READ:  first_byte = CMD_KEYREAD;
			ST_DIGIT: first_byte = addr_q;
			default:  first_byte = CMD_CONTROL;
		endcase
		unique case (step_q)
			ST_READ:  second_byte = 8'hFF;
			ST_DIGIT: second_byte = cursor_digit;
			default:  second_byte = sent_ctl_q;
		endcase
	end

	// Position inside the two data bytes of a transfer.
	assign ph_q       = phase_q - 6'd3;
	assign ph_second  = ph_q >= 6'd18;
	assign ph_q2      = ph_second ? ph_q - 6'd18 : ph_q;
	assign ph_bit     = ph_q2[4:1];
	assign ph_half    = ph_q2[0];
	assign shifted    = {shift_q[6:0], item.sda_in};
	assign cursor_inc = {1'b0, cursor_q} + 4'd1;

	always_comb begin
		step_n     = step_q;
		phase_n    = phase_q;
		shift_n    = shift_q;
		cursor_n   = cursor_q;
		addr_n     = addr_q;
		sent_ctl_n = sent_ctl_q;
		key_n      = key_q;
		alive_n    = alive_q;
		scl_n      = scl_q;
		sda_n      = sda_q;
		pending_n  = pending_q;
		sent_n     = sent_q;

		if (step_en) begin
			unique case (item.operation)
				OP_TICK: begin
					if (step_q != ST_IDLE) begin
						phase_n = phase_q + 6'd1;
						if (phase_q == 6'd0) begin
							scl_n = 1'b1;
							sda_n = 1'b1;
							if (step_q == ST_READ)
								key_n = 8'h00;
						end else if (phase_q == 6'd1) begin
							sda_n = 1'b0;
						end else if (phase_q == 6'd2) begin
							scl_n   = 1'b0;
							shift_n = first_byte;
						end else if (phase_q < PH_STOP) begin
							if (!ph_half) begin
								scl_n = 1'b1;
								if (ph_bit < 4'd8) begin
									sda_n   = shift_q[7];
									shift_n = shifted;
									if (ph_second && ph_bit == 4'd7 && step_q == ST_READ)
										key_n = shifted;
								end else begin
									sda_n = 1'b1;
									if (!ph_second && step_q != ST_DIGIT)
										alive_n = ~item.sda_in;
								end
							end else begin
								scl_n = 1'b0;
								if (!ph_second && ph_bit == 4'd8) begin
									// A command without acknowledge skips its data byte.
									if (step_q == ST_DIGIT || alive_q)
										shift_n = second_byte;
									else
										phase_n = PH_STOP;
								end
							end
						end else if (phase_q == PH_STOP) begin
							scl_n = 1'b0;
							sda_n = 1'b0;
						end else if (phase_q == PH_STOP + 6'd1) begin
							scl_n = 1'b1;
						end else begin
							// End of a transfer: decide what follows.
							sda_n   = 1'b1;
							phase_n = phase_q;
							unique case (step_q)
								ST_READ, ST_CFG_ALIVE: begin
									if (step_q == ST_READ && sent_ctl_q != cfg.display_control) begin
										sent_ctl_n = cfg.display_control;
										step_n     = ST_CFG_ALIVE;
										phase_n    = 6'd0;
									end else if (changed) begin
										for (int i = 0; i < MAX_DIGITS; i++) begin
											if (4'(i) < eff_cnt)
												sent_n[i] = pending_q[i];
										end
										cursor_n = 3'd0;
										addr_n   = cfg.base_addr;
										step_n   = ST_DIGIT;
										phase_n  = 6'd0;
									end else begin
										step_n = ST_IDLE;
									end
								end
								ST_CFG_DEAD: begin
									if (alive_q) begin
										cursor_n = 3'd0;
										addr_n   = cfg.base_addr;
										if (eff_cnt == 4'd0) begin
											step_n = ST_IDLE;
										end else begin
											step_n  = ST_DIGIT;
											phase_n = 6'd0;
										end
									end else begin
										step_n = ST_IDLE;
									end
								end
								ST_DIGIT: begin
									if (cursor_inc < eff_cnt) begin
										cursor_n = cursor_inc[2:0];
										addr_n   = addr_q - 8'd2;
										phase_n  = 6'd0;
									end else begin
										step_n = ST_IDLE;
									end
								end
								default: step_n = ST_IDLE;
							endcase
						end
					end
				end
				OP_LOAD: begin
					if (step_q == ST_IDLE) begin
						for (int i = 0; i < MAX_DIGITS; i++) begin
							if (4'(item.digit_index) == 4'(i))
								pending_n[i] = item.digit_value;
						end
					end
				end
				OP_UPDATE: begin
					if (step_q == ST_IDLE) begin
						step_n  = alive_q ? ST_READ : ST_CFG_DEAD;
						phase_n = 6'd0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= ST_IDLE;
			phase_q    <= 6'd0;
			shift_q    <= 8'h00;
			cursor_q   <= 3'd0;
			addr_q     <= 8'h00;
			sent_ctl_q <= DISPLAY_CONTROL_RST;
			key_q      <= 8'h00;
			alive_q    <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			for (int i = 0; i < MAX_DIGITS; i++) begin
				pending_q[i] <= 8'hFF;
				sent_q[i]    <= 8'h00;
			end
		end else begin
			step_q     <= step_n;
			phase_q    <= phase_n;
			shift_q    <= shift_n;
			cursor_q   <= cursor_n;
			addr_q     <= addr_n;
			sent_ctl_q <= sent_ctl_n;
			key_q      <= key_n;
			alive_q    <= alive_n;
			scl_q      <= scl_n;
			sda_q      <= sda_n;
			pending_q  <= pending_n;
			sent_q     <= sent_n;
		end
	end

	assign res_nxt.scl_out    = scl_n;
	assign res_nxt.sda_out    = sda_n;
	assign res_nxt.busy_res   = step_n != ST_IDLE;
	assign res_nxt.key_data   = key_n;
	assign res_nxt.link_alive = alive_n;

endmodule

`default_nettype wire

@@ sv/led_key_display_link_controller_top.sv @@
`default_nettype none

// Controller for a two-wire LED display and key scan chip. Each input transaction
// either ticks the link by one pin phase, loads a pending digit pattern, or requests
// an update; every accepted transaction returns exactly one result transaction with
// the line levels after it, the busy flag, the last key byte and the link-alive flag.
// The block takes one transaction per clock cycle: the sequencer state is updated
// in the cycle of acceptance and the result lands in a single output register, so
// a new transaction is taken whenever that register is empty or being emptied in
// the same cycle. The three configuration registers (digit count, first digit
// address, wanted control byte) are always ready and should only be written while
// no update sequence is in flight and no result is outstanding.
module led_key_display_link_controller_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire lkdl_pkg::lkdl_in_t item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output lkdl_pkg::lkdl_out_t     result,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data
);
	import lkdl_pkg::*;

	lkdl_cfg_t cfg_q;
	lkdl_out_t res_nxt;
	lkdl_out_t result_q;
	logic      result_valid_q;
	logic      item_fire;

	// The configuration port never stalls.
	assign cfg_ready = 1'b1;

	// A transaction enters when the output register is free or drains this cycle.
	assign item_ready = !result_valid_q || result_ready;
	assign item_fire  = item_valid && item_ready;

	// Writes to an index beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.digit_count     <= DIGIT_COUNT_RST;
			cfg_q.base_addr       <= BASE_ADDR_RST;
			cfg_q.display_control <= DISPLAY_CONTROL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DIGIT_COUNT:     cfg_q.digit_count     <= cfg_data[2:0];
				REG_BASE_ADDR:       cfg_q.base_addr       <= cfg_data;
				REG_DISPLAY_CONTROL: cfg_q.display_control <= cfg_data;
				default: ;
			endcase
		end
	end

	// The core holds the sequencer and digit state and presents the result that
	// the current transaction produces.
	lkdl_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (item_fire),
		.item    (item),
		.cfg     (cfg_q),
		.res_nxt (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// The result payload needs no reset; it is qualified by result_valid.
	always_ff @(posedge clk) begin
		if (item_fire)
			result_q <= res_nxt;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

@@ sv/lkdl_checker.sv @@
`default_nettype none

module lkdl_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                item_valid,
	input wire logic                item_ready,
	input wire logic                result_valid,
	input wire logic                result_ready,
	input wire lkdl_pkg::lkdl_out_t result
);
	import lkdl_pkg::*;

	// A stalled result holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Every accepted input transaction yields a result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("accepted transaction produced no result");

	// With the output register empty the block must take input.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with empty output");

	// Outside an update sequence both lines are released.
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.busy_res |-> result.scl_out && result.sda_out)
		else $error("lines not released while idle");

endmodule

bind led_key_display_link_controller_top lkdl_checker u_lkdl_checker (.*);

`default_nettype wire

@@ tb/lkdl_result_checker.sv @@
`timescale 1ns / 1ps

// Watches the item, result and register channels of the link controller, keeps
// its own copy of the controller state and checks every result in order.
module lkdl_result_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	input  wire logic                item_ready,
	input  wire lkdl_pkg::lkdl_in_t  item,
	input  wire logic                result_valid,
	input  wire logic                result_ready,
	input  wire lkdl_pkg::lkdl_out_t result,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [7:0]          cfg_data,
	output int                       fail_count,
	output int                       outstanding
);
	import lkdl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CTL_LIVE,
		S_DIGIT,
		S_CTL_DEAD
	} link_seq_t;

	localparam int STOP_PH = 39;
	localparam int LAST_PH = 41;

	// Register copies.
	logic [2:0] dcount;
	logic [7:0] faddr;
	logic [7:0] dctl;

	// Controller state copies.
	logic [7:0] pend [MAX_DIGITS];
	logic [7:0] sent [MAX_DIGITS];
	logic [7:0] ctl_sent;
	logic [7:0] key_reg;
	logic       alive;
	link_seq_t  seq_state;
	logic [5:0] phase;
	logic [7:0] shreg;
	logic [2:0] cursor;
	logic [7:0] addr;
	logic       scl;
	logic       sda;

	lkdl_out_t  results_due [$];

	function automatic int digits_used();
		return (dcount > MAX_DIGITS) ? MAX_DIGITS : int'(dcount);
	endfunction

	function automatic logic [7:0] head_byte();
		case (seq_state)
			S_READ:  return CMD_KEYREAD;
			S_DIGIT: return addr;
			default: return CMD_CONTROL;
		endcase
	endfunction

	function automatic logic [7:0] tail_byte();
		case (seq_state)
			S_READ:  return 8'hFF;
			S_DIGIT: return (cursor < MAX_DIGITS) ? sent[cursor[1:0]] : 8'h00;
			default: return ctl_sent;
		endcase
	endfunction

	task automatic clear_state();
		dcount    = DIGIT_COUNT_RST;
		faddr     = BASE_ADDR_RST;
		dctl      = DISPLAY_CONTROL_RST;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			pend[i] = 8'hFF;
			sent[i] = 8'h00;
		end
		ctl_sent  = DISPLAY_CONTROL_RST;
		key_reg   = 8'h00;
		alive     = 1'b0;
		seq_state = S_IDLE;
		phase     = '0;
		shreg     = 8'h00;
		cursor    = '0;
		addr      = 8'h00;
		scl       = 1'b1;
		sda       = 1'b1;
	endtask

	task automatic start_step(input link_seq_t s);
		seq_state = s;
		phase = '0;
	endtask

	task automatic start_digits();
		cursor = '0;
		addr = faddr;
		if (digits_used() == 0) seq_state = S_IDLE;
		else start_step(S_DIGIT);
	endtask

	task automatic refresh_digits();
		bit changed;
		changed = 1'b0;
		for (int i = 0; i < digits_used(); i++) begin
			if (sent[i] != pend[i]) begin
				sent[i] = pend[i];
				changed = 1'b1;
			end
		end
		if (changed) start_digits();
		else seq_state = S_IDLE;
	endtask

	task automatic close_transfer();
		case (seq_state)
			S_READ: begin
				if (ctl_sent != dctl) begin
					ctl_sent = dctl;
					start_step(S_CTL_LIVE);
				end else begin
					refresh_digits();
				end
			end
			S_CTL_LIVE: refresh_digits();
			S_CTL_DEAD: begin
				if (alive) start_digits();
				else seq_state = S_IDLE;
			end
			S_DIGIT: begin
				if (int'(cursor) + 1 < digits_used()) begin
					cursor = cursor + 3'd1;
					addr = addr - 8'd2;
					start_step(S_DIGIT);
				end else begin
					seq_state = S_IDLE;
				end
			end
			default: seq_state = S_IDLE;
		endcase
	endtask

	// One pin phase of the serial link.
	task automatic pin_phase(input logic sda_i);
		int p;
		int q;
		int bitn;
		int nxt;
		bit second;
		bit half;
		p = int'(phase);
		if (seq_state == S_IDLE) return;
		if (p == 0) begin
			scl = 1'b1;
			sda = 1'b1;
			if (seq_state == S_READ) key_reg = 8'h00;
		end else if (p == 1) begin
			sda = 1'b0;
		end else if (p == 2) begin
			scl = 1'b0;
			shreg = head_byte();
		end else if (p < STOP_PH) begin
			q = p - 3;
			second = (q >= 18);
			if (second) q = q - 18;
			bitn = q >> 1;
			half = q[0];
			if (!half) begin
				scl = 1'b1;
				if (bitn < 8) begin
					sda = shreg[7];
					shreg = {shreg[6:0], sda_i};
					if (second && bitn == 7 && seq_state == S_READ) key_reg = shreg;
				end else begin
					sda = 1'b1;
					if (!second && seq_state != S_DIGIT) alive = !sda_i;
				end
			end else begin
				scl = 1'b0;
				if (!second && bitn == 8) begin
					// A refused command byte skips straight to the stop condition.
					if (seq_state == S_DIGIT || alive) shreg = tail_byte();
					else p = STOP_PH - 1;
				end
			end
		end else if (p == STOP_PH) begin
			scl = 1'b0;
			sda = 1'b0;
		end else if (p == STOP_PH + 1) begin
			scl = 1'b1;
		end else begin
			sda = 1'b1;
			close_transfer();
			return;
		end
		nxt = (p + 1) & 63;
		if (nxt > LAST_PH) nxt = LAST_PH;
		phase = nxt[5:0];
	endtask

	task automatic predict_result(input lkdl_in_t it, output lkdl_out_t r);
		logic busy;
		busy = (seq_state != S_IDLE);
		case (it.operation)
			OP_TICK: pin_phase(it.sda_in);
			OP_LOAD: begin
				if (!busy && it.digit_index < MAX_DIGITS) pend[it.digit_index] = it.digit_value;
			end
			OP_UPDATE: begin
				if (!busy) begin
					if (alive) start_step(S_READ);
					else start_step(S_CTL_DEAD);
				end
			end
			default: ;
		endcase
		r.scl_out    = scl;
		r.sda_out    = sda;
		r.busy_res   = (seq_state != S_IDLE);
		r.key_data   = key_reg;
		r.link_alive = alive;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lkdl_out_t want;
		lkdl_out_t due;
		if (!arst_n) begin
			clear_state();
			results_due.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (results_due.size() == 0) begin
					$error("result transaction arrived with no item waiting for it");
					fail_count++;
				end else begin
					due = results_due.pop_front();
					if (result.scl_out !== due.scl_out) begin
						$error("scl_out: expected %0d, actual %0d", due.scl_out, result.scl_out);
						fail_count++;
					end
					if (result.sda_out !== due.sda_out) begin
						$error("sda_out: expected %0d, actual %0d", due.sda_out, result.sda_out);
						fail_count++;
					end
					if (result.busy_res !== due.busy_res) begin
						$error("busy_res: expected %0d, actual %0d", due.busy_res,
							result.busy_res);
						fail_count++;
					end
					if (result.key_data !== due.key_data) begin
						$error("key_data: expected %02h, actual %02h", due.key_data,
							result.key_data);
						fail_count++;
					end
					if (result.link_alive !== due.link_alive) begin
						$error("link_alive: expected %0d, actual %0d", due.link_alive,
							result.link_alive);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DIGIT_COUNT:     dcount = cfg_data[2:0];
					REG_BASE_ADDR:       faddr = cfg_data;
					REG_DISPLAY_CONTROL: dctl = cfg_data;
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				predict_result(item, want);
				results_due.push_back(want);
			end
			outstanding = results_due.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Top of the link controller testbench. This module only produces stimulus and
// gives the verdict; the checker instance beside the block predicts and compares
// every result transaction.
module tb;
	import lkdl_pkg::*;

	// Operation code and register index that the block defines as doing nothing.
	localparam logic [1:0] OP_SPARE  = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam int ITEM_TARGET    = 750;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	lkdl_in_t   item = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	lkdl_out_t  result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	int fail_count;
	int outstanding;

	// Idling controls for the two sides of the block.
	bit item_gaps = 1'b0;
	bit result_gaps = 1'b0;
	int stall_left = 0;

	// Bookkeeping used to steer the stimulus and to write the summary.
	int unsigned items_accepted = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned updates_sent = 0;
	int unsigned cfg_rounds = 0;
	int unsigned key_hits = 0;
	logic        last_busy = 1'b0;
	logic [7:0]  ctl_now = DISPLAY_CONTROL_RST;
	int          idle_cycles = 0;

	led_key_display_link_controller_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	lkdl_result_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap lengths: most are zero or short, a few are long enough to starve the
	// block for a good part of a byte on the link.
	function automatic int pick_gap(input bit on);
		int r;
		if (!on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// The result side stalls on its own schedule. When stalls are switched off the
	// receiver is always ready, which gives stretches of back-to-back transactions.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (result_gaps && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap(1'b1);
			result_ready <= (stall_left == 0);
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Track what the block reports, and end the run if no channel has moved a
	// transaction for too long.
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			results_seen <= results_seen + 1;
			last_busy <= result.busy_res;
			if (result.key_data != 8'h00) key_hits <= key_hits + 1;
		end
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("led_key_display_link_controller_top test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one item transaction. The task is entered and left at a falling edge.
	// Valid stays high on return so that a following call can present its item
	// without a bubble; callers that stop sending lower it themselves.
	task automatic send_item(input lkdl_in_t it, input bit counts);
		int g;
		g = pick_gap(item_gaps);
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_accepted++;
		if (counts) items_sent++;
		@(negedge clk);
	endtask

	// Write one register. Like send_item, valid is left high on return.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic lkdl_in_t make_item(input logic [1:0] op, input logic [1:0] idx,
			input logic [7:0] val, input logic sda_i);
		lkdl_in_t it;
		it.operation = op;
		it.digit_index = idx;
		it.digit_value = val;
		it.sda_in = sda_i;
		return it;
	endfunction

	// Bring the block to rest: every expected result has come back and the last
	// one shows no update sequence running. If a sequence is still going, it is
	// ticked along with the data line released, which makes the chip look silent
	// and cuts the sequence short.
	task automatic settle();
		forever begin
			item_valid <= 1'b0;
			@(negedge clk);
			while (outstanding != 0) @(negedge clk);
			if (!last_busy) break;
			repeat (8) send_item(make_item(OP_TICK, 2'($urandom), 8'($urandom), 1'b1), 1'b0);
		end
	endtask

	// Program all three registers. The first rounds take the extremes; later ones
	// favor small digit counts so that update sequences stay short, and often keep
	// the control byte so that the unchanged-control path is taken too.
	task automatic program_round(input int r);
		logic [2:0] cnt;
		logic [7:0] fa;
		logic [7:0] dc;
		logic [7:0] d;
		case (r)
			0: begin cnt = 3'd1; fa = 8'h00; dc = 8'h00; end
			1: begin cnt = 3'd7; fa = 8'hFF; dc = 8'hFF; end
			2: begin cnt = 3'd0; fa = 8'h01; dc = 8'h80; end
			3: begin cnt = 3'd4; fa = 8'h03; dc = 8'h7F; end
			default: begin
				if ($urandom_range(0, 3) == 0) cnt = 3'($urandom_range(0, 7));
				else cnt = 3'($urandom_range(1, 2));
				fa = 8'($urandom);
				dc = ($urandom_range(0, 1) == 0) ? ctl_now : 8'($urandom);
			end
		endcase
		// Only the low three bits of the digit count are kept, so the upper ones
		// carry noise.
		d = 8'($urandom);
		d[2:0] = cnt;
		write_reg(REG_DIGIT_COUNT, d);
		write_reg(REG_BASE_ADDR, fa);
		write_reg(REG_DISPLAY_CONTROL, dc);
		if (r == 1 || $urandom_range(0, 7) == 0) write_reg(REG_SPARE, 8'($urandom));
		cfg_valid <= 1'b0;
		@(negedge clk);
		ctl_now = dc;
		cfg_rounds++;
	endtask

	// One update sequence with random content: a few digit loads, the request,
	// and then ticks until the block reports idle again. A small share of the
	// items are loads, requests and spare operations thrown in while it is busy.
	task automatic run_sequence();
		int n;
		int thr;
		int k;
		int unsigned upd_idx;
		lkdl_in_t it;
		item_gaps = ($urandom_range(0, 3) != 0);
		result_gaps = ($urandom_range(0, 3) != 0);
		// The data line is high with probability thr/16 on each tick: a fair coin
		// gives random key bytes, the other two settings mostly acknowledge or
		// mostly refuse the command bytes.
		case ($urandom_range(0, 2))
			0: thr = 8;
			1: thr = 1;
			default: thr = 15;
		endcase
		n = $urandom_range(0, 4);
		repeat (n) send_item(make_item(OP_LOAD, 2'($urandom), 8'($urandom), 1'($urandom)),
			1'b1);
		send_item(make_item(OP_UPDATE, 2'($urandom), 8'($urandom), 1'($urandom)), 1'b1);
		updates_sent++;
		upd_idx = items_accepted;
		while (!(results_seen >= upd_idx && !last_busy)) begin
			k = $urandom_range(0, 19);
			it = make_item(OP_TICK, 2'($urandom), 8'($urandom),
				($urandom_range(0, 15) < thr));
			if (k < 17) begin
				send_item(it, 1'b1);
			end else begin
				if (k == 17) it.operation = OP_LOAD;
				else if (k == 18) it.operation = OP_UPDATE;
				else it.operation = OP_SPARE;
				send_item(it, 1'b0);
			end
		end
		item_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Directed opening with the reset register values: the spare operation, idle
	// ticks, loads with extreme patterns on every digit, then an update on a dead
	// link that the chip refuses. Loads and requests issued while that sequence
	// runs must be ignored.
	task automatic directed_part();
		send_item(make_item(OP_SPARE, 2'd3, 8'hFF, 1'b1), 1'b0);
		send_item(make_item(OP_TICK, 2'd0, 8'h00, 1'b0), 1'b1);
		send_item(make_item(OP_TICK, 2'd3, 8'hFF, 1'b1), 1'b1);
		send_item(make_item(OP_LOAD, 2'd0, 8'h00, 1'b0), 1'b1);
		send_item(make_item(OP_LOAD, 2'd1, 8'hFF, 1'b1), 1'b1);
		send_item(make_item(OP_LOAD, 2'd2, 8'h80, 1'b0), 1'b1);
		send_item(make_item(OP_LOAD, 2'd3, 8'h7F, 1'b1), 1'b1);
		send_item(make_item(OP_UPDATE, 2'd0, 8'h00, 1'b0), 1'b1);
		updates_sent++;
		for (int i = 0; i < 24; i++) begin
			if (i == 5) send_item(make_item(OP_LOAD, 2'd1, 8'h55, 1'b1), 1'b0);
			if (i == 9) send_item(make_item(OP_UPDATE, 2'd2, 8'hAA, 1'b1), 1'b0);
			send_item(make_item(OP_TICK, 2'd0, 8'h00, 1'b1), 1'b1);
		end
		item_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int round;
		// Reset is held from the start and released on a falling edge.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_part();

		// Random rounds: a new register setting, written only once the block is at
		// rest, followed by two update sequences.
		round = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			program_round(round);
			repeat (2) run_sequence();
			round++;
		end

		// Let everything drain, then allow a few cycles for any stray result.
		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d item transactions with %0d update requests",
			items_accepted, updates_sent);
		$display("across %0d register settings; checked %0d results, %0d with a key byte.",
			cfg_rounds, results_seen, key_hits);
		if (fail_count == 0 && outstanding == 0) begin
			$display("led_key_display_link_controller_top test passed");
		end else begin
			$display("led_key_display_link_controller_top test failed");
		end
		$finish;
	end

endmodule
